/* hw/rtl/alpi_pkg.sv */
// ----------------------------------------------------------------------------
// alpi_pkg
// Shared types and codes of the arc-length path interpolator.
// ----------------------------------------------------------------------------
package alpi_pkg;

    localparam int WORD_W = 32;
    localparam int ARC_W  = 31;
    localparam int DIR_W  = 18;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [ARC_W-1:0] ARC_MAX = 31'h7FFF_FFFF;

    // one path point as stored in the point memory
    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
        logic [ARC_W-1:0]  arc;
    } row_t;

endpackage

/* hw/rtl/arc_length_path_interpolator.sv */
// ----------------------------------------------------------------------------
// arc_length_path_interpolator
// Path point store with arc-length lookup and linear interpolation.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): action 0 loads one point (start_new
// empties the path first), action 1 queries the path at arc length query_s.
// Output channel (out_valid/out_ready): one result word per input word.
// All points live in one row memory (x, y, bounds, cumulative arc length).
// Load: segment length by a bit-serial square root, 32 steps; the first
// point and an overflowed delta skip the square root.
// Query: binary search over the arc column, three row reads, then up to
// four interpolations and two direction divisions on one shared restoring
// divider, one quotient bit per cycle.
// One word is processed at a time; in_ready is high while the block is idle.
// A finished result sits in the output register, so the next word can be
// accepted while the receiver stalls; the block then holds its next result
// until the output register is free.
// Reset empties the path; memory contents are not cleared.
// ----------------------------------------------------------------------------
module arc_length_path_interpolator #(
    parameter int MAX_POINTS = 1024,
    parameter int FRAC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic        start_new,
    input  logic [31:0] point_x,
    input  logic [31:0] point_y,
    input  logic [31:0] point_left,
    input  logic [31:0] point_right,
    input  logic [31:0] query_s,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] ref_x,
    output logic [31:0] ref_y,
    output logic [31:0] ref_left,
    output logic [31:0] ref_right,
    output logic [17:0] dir_x,
    output logic [17:0] dir_y,
    output logic [30:0] total_length
);

    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int DQ_W   = FRAC_BITS + 2;
    localparam int DS_MIN = (2 ** FRAC_BITS + 999999) / 1000000;
    localparam logic [DQ_W-1:0] ONE_Q = DQ_W'(1) << FRAC_BITS;

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_SQA   = 18'h00002,
        S_SQB   = 18'h00004,
        S_SQC   = 18'h00008,
        S_SQRT  = 18'h00010,
        S_WRITE = 18'h00020,
        S_SRCH  = 18'h00040,
        S_SCMP  = 18'h00080,
        S_RD0   = 18'h00100,
        S_RD1   = 18'h00200,
        S_RD2   = 18'h00400,
        S_RD3   = 18'h00800,
        S_OPSET = 18'h01000,
        S_OPMUL = 18'h02000,
        S_DINIT = 18'h04000,
        S_DIV   = 18'h08000,
        S_OPFIN = 18'h10000,
        S_OUT   = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    alpi_pkg::row_t mem [MAX_POINTS];
    alpi_pkg::row_t rd_row_reg;
    alpi_pkg::row_t rowa_reg, rowb_reg, rowe_reg;
    alpi_pkg::row_t wr_row;
    logic [AW-1:0]  rd_addr;
    logic           mem_we;

    logic [CW-1:0]  count_reg;
    logic [31:0]    last_x_reg, last_y_reg;
    logic [30:0]    last_arc_reg;

    logic [AW-1:0]  idx_reg;
    logic           first_reg;
    logic [31:0]    px_reg, py_reg, pl_reg, pr_reg;
    logic [30:0]    ax_reg, ay_reg;
    logic [31:0]    d_reg;
    logic [63:0]    prod_reg, rad_reg, root_reg;
    logic [4:0]     jcnt_reg;

    logic [31:0]    s_reg;
    logic           s_lo_reg, s_hi_reg;
    logic [30:0]    sc_reg;
    logic [CW-1:0]  lo_reg, hi_reg, mid_reg;

    logic [2:0]     op_reg;
    logic [31:0]    mag_reg;
    logic           neg_reg;
    logic [31:0]    rem_reg;
    logic [63:0]    dvd_reg;
    logic [31:0]    quo_reg;
    logic [5:0]     dcnt_reg;
    logic           ovf_reg;

    logic [1:0]     res_status_reg;
    logic [31:0]    res_pt_reg [4];
    logic [DQ_W-1:0] res_dx_reg, res_dy_reg;

    logic           out_valid_reg;
    logic [1:0]     status_reg;
    logic [31:0]    ref_x_reg, ref_y_reg, ref_left_reg, ref_right_reg;
    logic [17:0]    dir_x_reg, dir_y_reg;
    logic [30:0]    total_reg;

    function automatic logic [31:0] fsel(alpi_pkg::row_t r, logic [1:0] f);
        logic [31:0] v;
        unique case (f)
            2'd0: v = r.x;
            2'd1: v = r.y;
            2'd2: v = r.left;
            2'd3: v = r.right;
        endcase
        return v;
    endfunction

    // ---------------- combinational helpers ----------------
    logic           accept, out_free;
    logic [CW-1:0]  n_eff;
    logic signed [32:0] ddx, ddy;
    logic [32:0]    adx, ady;
    logic           big;
    logic [CW:0]    mid_sum;
    logic [CW-1:0]  mid_c;
    logic [CW-1:0]  km1, seg_c, e_c;
    logic [30:0]    den, num;
    logic           interior, dir_en, is_dir;
    logic [1:0]     fidx;
    logic [31:0]    fa, fb;
    logic [32:0]    fd;
    logic [63:0]    bitv, trial, root_n, rad_n;
    logic           take;
    logic [31:0]    mul_a, mul_b;
    logic [31:0]    dstep;
    logic           dge;
    logic [63:0]    dvd_dir;
    logic [32:0]    lsum, aext, qext;
    logic [DQ_W-1:0] qs, dirv;
    logic [32:0]    arc_sum;
    logic [30:0]    arc_new;
    logic signed [32:0] s_ext, last_ext;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign n_eff    = start_new ? '0 : count_reg;

    assign ddx = {point_x[31], point_x} - {last_x_reg[31], last_x_reg};
    assign ddy = {point_y[31], point_y} - {last_y_reg[31], last_y_reg};
    assign adx = ddx[32] ? 33'(-ddx) : 33'(ddx);
    assign ady = ddy[32] ? 33'(-ddy) : 33'(ddy);
    assign big = adx[32] | adx[31] | ady[32] | ady[31];

    assign s_ext    = {query_s[31], query_s};
    assign last_ext = {2'b00, last_arc_reg};

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_c   = mid_sum[CW:1];

    always_comb
    begin
        km1 = (lo_reg == '0) ? '0 : lo_reg - CW'(1);
        seg_c = km1;
        if (count_reg >= CW'(2) && km1 > count_reg - CW'(2))
        begin
            seg_c = count_reg - CW'(2);
        end
        e_c = s_lo_reg ? '0 : count_reg - CW'(1);
    end

    assign den      = rowb_reg.arc - rowa_reg.arc;
    assign num      = s_reg[30:0] - rowa_reg.arc;
    assign interior = !s_lo_reg && !s_hi_reg;
    assign dir_en   = (count_reg >= CW'(2)) && (32'(den) >= 32'(DS_MIN));
    assign is_dir   = op_reg[2];
    assign fidx     = is_dir ? {1'b0, op_reg[0]} : op_reg[1:0];
    assign fa       = fsel(rowa_reg, fidx);
    assign fb       = fsel(rowb_reg, fidx);
    assign fd       = {fb[31], fb} - {fa[31], fa};

    assign bitv   = 64'(1) << {jcnt_reg, 1'b0};
    assign trial  = root_reg + bitv;
    assign take   = rad_reg >= trial;
    assign root_n = take ? (root_reg >> 1) + bitv : root_reg >> 1;
    assign rad_n  = take ? rad_reg - trial : rad_reg;

    always_comb
    begin
        unique case (state_reg)
            S_SQA:   begin mul_a = {1'b0, ax_reg}; mul_b = {1'b0, ax_reg}; end
            S_SQB:   begin mul_a = {1'b0, ay_reg}; mul_b = {1'b0, ay_reg}; end
            default: begin mul_a = mag_reg;        mul_b = {1'b0, num};    end
        endcase
    end

    assign dstep   = {rem_reg[30:0], dvd_reg[63]};
    assign dge     = dstep >= {1'b0, den};
    assign dvd_dir = 64'(mag_reg) << FRAC_BITS;

    assign aext = {fa[31], fa};
    assign qext = {1'b0, quo_reg};
    assign lsum = neg_reg ? aext - qext : aext + qext;

    assign qs   = (ovf_reg || quo_reg > 32'(ONE_Q)) ? ONE_Q : quo_reg[DQ_W-1:0];
    assign dirv = neg_reg ? DQ_W'(-qs) : qs;

    assign arc_sum = {2'b00, last_arc_reg} + {1'b0, d_reg};
    assign arc_new = first_reg ? '0 :
                     (arc_sum > {2'b00, alpi_pkg::ARC_MAX}) ? alpi_pkg::ARC_MAX :
                     arc_sum[30:0];

    // ---------------- memory ----------------
    always_comb
    begin
        unique case (state_reg)
            S_RD0:   rd_addr = seg_c[AW-1:0];
            S_RD1:   rd_addr = AW'(seg_c[AW-1:0] + AW'(1));
            S_RD2:   rd_addr = e_c[AW-1:0];
            default: rd_addr = mid_c[AW-1:0];
        endcase
    end

    assign mem_we = (state_reg == S_WRITE);
    assign wr_row = '{x: px_reg, y: py_reg, left: pl_reg, right: pr_reg, arc: arc_new};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= wr_row;
        end
        rd_row_reg <= mem[rd_addr];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == alpi_pkg::ACT_LOAD)
                    begin
                        if (n_eff >= CW'(MAX_POINTS))  state_next = S_OUT;
                        else if (n_eff == '0 || big)   state_next = S_WRITE;
                        else                           state_next = S_SQA;
                    end
                    else if (count_reg == '0)          state_next = S_OUT;
                    else                               state_next = S_SRCH;
                end
            end
            S_SQA:   state_next = S_SQB;
            S_SQB:   state_next = S_SQC;
            S_SQC:   state_next = S_SQRT;
            S_SQRT:  if (jcnt_reg == '0) state_next = S_WRITE;
            S_WRITE: state_next = S_OUT;
            S_SRCH:  state_next = (lo_reg < hi_reg) ? S_SCMP : S_RD0;
            S_SCMP:  state_next = S_SRCH;
            S_RD0:   state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_RD3;
            S_RD3:   state_next = S_OPSET;
            S_OPSET:
            begin
                if (!is_dir)       state_next = interior ? S_OPMUL : S_OPFIN;
                else if (!dir_en)  state_next = S_OUT;
                else               state_next = S_DINIT;
            end
            S_OPMUL: state_next = S_DINIT;
            S_DINIT: state_next = (is_dir && (dvd_dir >> DQ_W) >= 64'(den)) ? S_OPFIN : S_DIV;
            S_DIV:   if (dcnt_reg == 6'd1) state_next = S_OPFIN;
            S_OPFIN: state_next = (op_reg == 3'd5) ? S_OUT : S_OPSET;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_WRITE)
            begin
                count_reg <= CW'(idx_reg) + CW'(1);
            end
            else if (accept && action == alpi_pkg::ACT_LOAD && start_new)
            begin
                count_reg <= '0;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_reg         <= '0;
                    ovf_reg        <= 1'b0;
                    res_status_reg <= alpi_pkg::STATUS_OK;
                    for (int f = 0; f < 4; f++)
                    begin
                        res_pt_reg[f] <= '0;
                    end
                    res_dx_reg <= '0;
                    res_dy_reg <= '0;
                    if (action == alpi_pkg::ACT_LOAD)
                    begin
                        if (n_eff >= CW'(MAX_POINTS))
                        begin
                            res_status_reg <= alpi_pkg::STATUS_FULL;
                        end
                        idx_reg   <= n_eff[AW-1:0];
                        first_reg <= (n_eff == '0);
                        px_reg    <= point_x;
                        py_reg    <= point_y;
                        pl_reg    <= point_left;
                        pr_reg    <= point_right;
                        ax_reg    <= adx[30:0];
                        ay_reg    <= ady[30:0];
                        d_reg     <= 32'h8000_0000;
                    end
                    else
                    begin
                        res_dx_reg <= ONE_Q;
                        if (count_reg == '0)
                        begin
                            res_status_reg <= alpi_pkg::STATUS_EMPTY;
                        end
                        s_reg    <= query_s;
                        s_lo_reg <= (s_ext <= 33'sd0);
                        s_hi_reg <= (s_ext >= last_ext);
                        if (s_ext <= 33'sd0)           sc_reg <= '0;
                        else if (s_ext >= last_ext)    sc_reg <= last_arc_reg;
                        else                           sc_reg <= query_s[30:0];
                        lo_reg <= '0;
                        hi_reg <= count_reg;
                    end
                end
            end
            S_SQA:   prod_reg <= 64'(mul_a) * 64'(mul_b);
            S_SQB:
            begin
                rad_reg  <= prod_reg;
                prod_reg <= 64'(mul_a) * 64'(mul_b);
            end
            S_SQC:
            begin
                rad_reg  <= rad_reg + prod_reg;
                root_reg <= '0;
                jcnt_reg <= 5'd31;
            end
            S_SQRT:
            begin
                rad_reg  <= rad_n;
                root_reg <= root_n;
                jcnt_reg <= jcnt_reg - 5'd1;
                if (jcnt_reg == '0)
                begin
                    d_reg <= root_n[31:0];
                end
            end
            S_WRITE:
            begin
                last_x_reg   <= px_reg;
                last_y_reg   <= py_reg;
                last_arc_reg <= arc_new;
            end
            S_SRCH:  mid_reg <= mid_c;
            S_SCMP:
            begin
                if (rd_row_reg.arc < sc_reg) lo_reg <= mid_reg + CW'(1);
                else                         hi_reg <= mid_reg;
            end
            S_RD1:   rowa_reg <= rd_row_reg;
            S_RD2:   rowb_reg <= rd_row_reg;
            S_RD3:   rowe_reg <= rd_row_reg;
            S_OPSET:
            begin
                neg_reg <= fd[32];
                mag_reg <= fd[32] ? 32'(-fd) : fd[31:0];
                if (!is_dir && !interior)
                begin
                    res_pt_reg[op_reg[1:0]] <= fsel(rowe_reg, op_reg[1:0]);
                end
                if (is_dir && !dir_en)
                begin
                    res_dx_reg <= ONE_Q;
                    res_dy_reg <= '0;
                end
            end
            S_OPMUL: prod_reg <= 64'(mul_a) * 64'(mul_b);
            S_DINIT:
            begin
                quo_reg <= '0;
                if (is_dir)
                begin
                    rem_reg  <= 32'(dvd_dir >> DQ_W);
                    dvd_reg  <= dvd_dir << (64 - DQ_W);
                    dcnt_reg <= 6'(DQ_W);
                    ovf_reg  <= (dvd_dir >> DQ_W) >= 64'(den);
                end
                else
                begin
                    rem_reg  <= prod_reg[63:32];
                    dvd_reg  <= {prod_reg[31:0], 32'h0};
                    dcnt_reg <= 6'd32;
                    ovf_reg  <= 1'b0;
                end
            end
            S_DIV:
            begin
                rem_reg  <= dge ? dstep - {1'b0, den} : dstep;
                dvd_reg  <= dvd_reg << 1;
                quo_reg  <= {quo_reg[30:0], dge};
                dcnt_reg <= dcnt_reg - 6'd1;
            end
            S_OPFIN:
            begin
                op_reg <= op_reg + 3'd1;
                if (!is_dir && interior)
                begin
                    res_pt_reg[op_reg[1:0]] <= lsum[31:0];
                end
                if (is_dir && !op_reg[0])
                begin
                    res_dx_reg <= dirv;
                end
                if (is_dir && op_reg[0])
                begin
                    res_dy_reg <= dirv;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    status_reg    <= res_status_reg;
                    ref_x_reg     <= res_pt_reg[0];
                    ref_y_reg     <= res_pt_reg[1];
                    ref_left_reg  <= res_pt_reg[2];
                    ref_right_reg <= res_pt_reg[3];
                    dir_x_reg     <= 18'($signed(res_dx_reg));
                    dir_y_reg     <= 18'($signed(res_dy_reg));
                    total_reg     <= (count_reg == '0) ? '0 : last_arc_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign ref_x        = ref_x_reg;
    assign ref_y        = ref_y_reg;
    assign ref_left     = ref_left_reg;
    assign ref_right    = ref_right_reg;
    assign dir_x        = dir_x_reg;
    assign dir_y        = dir_y_reg;
    assign total_length = total_reg;

endmodule

/* hw/rtl/alpi_checker.sv */
// ----------------------------------------------------------------------------
// alpi_checker
// Port-level checks of the arc-length path interpolator.
// ----------------------------------------------------------------------------
module alpi_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [31:0] ref_x,
    input logic [17:0] dir_x,
    input logic [17:0] dir_y,
    input logic [30:0] total_length
);

    localparam logic [17:0] ONE_D = 18'(64'(1) << FRAC_BITS);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ref_x) && $stable(status))
        else $error("stalled output word changed");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == alpi_pkg::STATUS_EMPTY |->
            total_length == '0 && ref_x == '0 && dir_x == ONE_D && dir_y == '0)
        else $error("bad empty-query word");

    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == alpi_pkg::STATUS_FULL |->
            ref_x == '0 && dir_x == '0 && dir_y == '0)
        else $error("bad dropped-load word");

endmodule

bind arc_length_path_interpolator alpi_checker #(.FRAC_BITS(FRAC_BITS)) u_alpi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .ref_x        (ref_x),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .total_length (total_length)
);
